### sv/sleep_queue_tick_waker_assert.svh
// Assertion macros used by the checker module of the sleep queue block.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef SLEEP_QUEUE_TICK_WAKER_ASSERT_SVH
`define SLEEP_QUEUE_TICK_WAKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQTW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sleep queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SQTW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sleep queue assertion failed");

`endif

### sv/sqtw_pkg.sv
package sqtw_pkg;

  // Request codes.
  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_WOKEN   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  thread_id;
    logic [15:0] sleep_ticks;
    logic        cpu_idle;
    logic        future_pending;
  } req_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] woken_id;
    logic       disable_timer;
    logic       yield_on_return;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUMMARY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sleep;
    logic tick_start;
    logic scan;
    logic summary;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

### sv/sleep_queue_tick_waker.sv
// Sleep queue with tick waker: a table of sleeping threads and a tick counter.
// A transaction is accepted at a clock edge where start is high and busy is low;
// its fields arrive on req. A sleep request stores the thread with wake tick
// counter + sleep_ticks and answers with one result in the next cycle; busy
// stays low, so another transaction can follow right after it.
// A tick raises busy until its summary is formed: the stored table is read one
// entry per cycle through its single registered read port, each woken thread
// comes out as a result, and the survivors are written back in order. The
// summary result, marked by last, appears in the cycle busy drops.
// Each result is shown on result for one cycle with result_valid high; the
// receiver cannot stall, so no result waits.
// The preemptive_sched register is written through cfg_we and cfg_wdata.
// Reset clears the counter, empties the table and sets preemptive_sched to 1;
// the table needs no clearing pass because a fill count marks its used part.
module sleep_queue_tick_waker
  import sqtw_pkg::*;
#(
  parameter int MAX_SLEEPERS = 16,
  parameter int TICK_WIDTH   = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  output logic    result_valid,
  output result_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences sleep, scan and summary steps.
  sqtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // The datapath holds the counter, the table and the result register.
  sqtw_dp #(
    .MAX_SLEEPERS (MAX_SLEEPERS),
    .TICK_WIDTH   (TICK_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### sv/sqtw_ram.sv
module sqtw_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sqtw_ctrl.sv
module sqtw_ctrl
  import sqtw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     req_type,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (req_type == REQ_TICK) begin
            cmd.tick_start = 1'b1;
            state_next     = ST_SCAN;
          end else begin
            cmd.sleep = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_SUMMARY;
        end
      end
      ST_SUMMARY: begin
        cmd.summary = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/sqtw_dp.sv
module sqtw_dp
  import sqtw_pkg::*;
#(
  parameter int MAX_SLEEPERS = 16,
  parameter int TICK_WIDTH   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  req_t     req,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output logic     result_valid,
  output result_t  result
);

  localparam int CW = $clog2(MAX_SLEEPERS + 1);
  localparam int AW = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int EW = TICK_WIDTH + 8;

  logic [TICK_WIDTH-1:0] tick_count;
  logic [CW-1:0]         count;
  logic [CW-1:0]         rd_ptr;
  logic [CW-1:0]         wr_ptr;
  logic                  pend;
  logic                  woken;
  logic                  idle_q;
  logic                  fut_q;
  logic                  preempt;

  logic [TICK_WIDTH:0]   wake_sum;
  logic [TICK_WIDTH-1:0] wake_new;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic                  full;
  logic [EW-1:0]         rd_data;
  logic [TICK_WIDTH-1:0] rd_wake;
  logic [7:0]            rd_id;
  logic                  wakes;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;

  // Wake tick saturates at the counter maximum.
  assign wake_sum = {1'b0, tick_count} + {{(TICK_WIDTH + 1 - 16){1'b0}}, req.sleep_ticks};
  assign wake_new = wake_sum[TICK_WIDTH] ? {TICK_WIDTH{1'b1}} : wake_sum[TICK_WIDTH-1:0];
  assign tick_inc = (tick_count == {TICK_WIDTH{1'b1}}) ? tick_count
                                                       : tick_count + TICK_WIDTH'(1);
  assign full     = (count == CW'(MAX_SLEEPERS));

  assign rd_wake  = rd_data[EW-1:8];
  assign rd_id    = rd_data[7:0];
  assign wakes    = (rd_wake <= tick_count);

  // Survivors of a scan are written back compacted; a new sleeper goes to the end.
  assign ram_we    = (cmd.sleep && !full) || (cmd.scan && pend && !wakes);
  assign ram_waddr = cmd.sleep ? count[AW-1:0] : wr_ptr[AW-1:0];
  assign ram_wdata = cmd.sleep ? {wake_new, req.thread_id} : rd_data;

  assign stat.scan_done = (rd_ptr == count) && !pend;

  sqtw_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SLEEPERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      count        <= '0;
      pend         <= 1'b0;
      woken        <= 1'b0;
      preempt      <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        preempt <= cfg_wdata;
      end
      if (cmd.sleep) begin
        result_valid           <= 1'b1;
        result.disable_timer   <= 1'b0;
        result.yield_on_return <= 1'b0;
        result.last            <= 1'b1;
        if (full) begin
          result.result_kind <= KIND_REJECT;
          result.woken_id    <= '0;
        end else begin
          result.result_kind <= KIND_ACCEPT;
          result.woken_id    <= req.thread_id;
          count              <= count + CW'(1);
        end
      end
      if (cmd.tick_start) begin
        tick_count <= tick_inc;
        rd_ptr     <= '0;
        wr_ptr     <= '0;
        pend       <= 1'b0;
        woken      <= 1'b0;
        idle_q     <= req.cpu_idle;
        fut_q      <= req.future_pending;
      end
      if (cmd.scan) begin
        pend <= (rd_ptr != count);
        if (rd_ptr != count) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (pend) begin
          if (wakes) begin
            woken                  <= 1'b1;
            result_valid           <= 1'b1;
            result.result_kind     <= KIND_WOKEN;
            result.woken_id        <= rd_id;
            result.disable_timer   <= 1'b0;
            result.yield_on_return <= 1'b0;
            result.last            <= 1'b0;
          end else begin
            wr_ptr <= wr_ptr + CW'(1);
          end
        end
      end
      if (cmd.summary) begin
        count              <= wr_ptr;
        result_valid       <= 1'b1;
        result.result_kind <= KIND_SUMMARY;
        result.woken_id    <= '0;
        result.last        <= 1'b1;
        if (idle_q && !woken && (wr_ptr == '0)) begin
          result.disable_timer   <= !fut_q;
          result.yield_on_return <= 1'b0;
        end else begin
          result.disable_timer   <= 1'b0;
          result.yield_on_return <= preempt;
        end
      end
    end
  end

endmodule

### sv/sqtw_checker.sv
`include "sleep_queue_tick_waker_assert.svh"

module sqtw_checker
  import sqtw_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input req_t    req,
  input logic    result_valid,
  input result_t result
);

  logic sleep_accept;
  logic tick_accept;
  logic answer_ok;
  logic summary_ok;
  logic flags_clear;

  assign sleep_accept = start && !busy && (req.req_type == REQ_SLEEP);
  assign tick_accept  = start && !busy && (req.req_type == REQ_TICK);
  assign answer_ok    = result_valid && result.last &&
                        (result.result_kind == KIND_ACCEPT ||
                         result.result_kind == KIND_REJECT);
  assign summary_ok   = result_valid && result.last && (result.result_kind == KIND_SUMMARY);
  assign flags_clear  = !result.disable_timer && !result.yield_on_return;

  `SQTW_ASSERT_NXT(a_sleep_answer, sleep_accept, answer_ok)
  `SQTW_ASSERT_NXT(a_tick_busy, tick_accept, busy)
  `SQTW_ASSERT_IMP(a_summary_end, $fell(busy), summary_ok)
  `SQTW_ASSERT_IMP(a_not_last_woken, result_valid && !result.last, result.result_kind == KIND_WOKEN)
  `SQTW_ASSERT_IMP(a_flags_summary, result_valid && (result.result_kind != KIND_SUMMARY), flags_clear)

endmodule

bind sleep_queue_tick_waker sqtw_checker u_sqtw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req          (req),
  .result_valid (result_valid),
  .result       (result)
);

### test/sleep_queue_tick_waker_test.sv
`timescale 1ns / 100ps

module sleep_queue_tick_waker_test;
  import sqtw_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  // Drain time after the last result, well over what a tick over a full table takes.
  localparam int DRAIN_CYCLES = 40;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  req_t    req = '0;
  logic    cfg_we = 1'b0;
  logic    cfg_wdata = 1'b0;
  logic    result_valid;
  result_t result;

  sleep_queue_tick_waker dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .result       (result)
  );

  always #10 clk = ~clk;

  // Requests waiting to be driven, and results the sleep table should produce.
  req_t    queued_requests[$];
  result_t pending_results[$];
  int      idle_cycles = 0;
  int      error_count = 0;
  int      cycle_count = 0;

  // Shadow copy of the sleep table, the tick counter and the scheduler bit.
  logic [31:0] shadow_ticks;
  logic [31:0] shadow_wake[TABLE_DEPTH];
  logic [7:0]  shadow_thread[TABLE_DEPTH];
  int          shadow_fill;
  logic        shadow_preempt;

  // Appends one expected result behind the ones already waiting.
  function automatic void expect_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Appends one request behind the ones already waiting to be driven.
  function automatic void queue_request(req_t r);
    queued_requests.insert(queued_requests.size(), r);
  endfunction

  // Builds one result record with the given fields.
  function automatic result_t make_result(logic [1:0] kind, logic [7:0] id, logic dis,
                                          logic yld, logic fin);
    result_t r;
    r.result_kind     = kind;
    r.woken_id        = id;
    r.disable_timer   = dis;
    r.yield_on_return = yld;
    r.last            = fin;
    return r;
  endfunction

  // Advances the shadow table by one accepted transaction and queues the
  // results it must cause, in the order the block emits them.
  function automatic void predict_results(req_t r);
    logic [32:0] wake_sum;
    int          idx;
    int          k;
    logic        woke;
    logic        dis;
    logic        yld;
    if (r.req_type == REQ_SLEEP) begin
      if (shadow_fill >= TABLE_DEPTH) begin
        expect_result(make_result(KIND_REJECT, 8'h00, 1'b0, 1'b0, 1'b1));
      end else begin
        // The wake tick saturates at the counter maximum.
        wake_sum = {1'b0, shadow_ticks} + 33'(r.sleep_ticks);
        shadow_wake[shadow_fill]   = wake_sum[32] ? '1 : wake_sum[31:0];
        shadow_thread[shadow_fill] = r.thread_id;
        shadow_fill++;
        expect_result(make_result(KIND_ACCEPT, r.thread_id, 1'b0, 1'b0, 1'b1));
      end
    end else begin
      if (shadow_ticks != '1) shadow_ticks++;
      idx  = 0;
      woke = 1'b0;
      // Wake sleepers oldest first; a removal shifts the later ones down.
      while (idx < shadow_fill) begin
        if (shadow_wake[idx] <= shadow_ticks) begin
          expect_result(make_result(KIND_WOKEN, shadow_thread[idx], 1'b0, 1'b0, 1'b0));
          for (k = idx; k < shadow_fill - 1; k++) begin
            shadow_wake[k]   = shadow_wake[k + 1];
            shadow_thread[k] = shadow_thread[k + 1];
          end
          shadow_fill--;
          woke = 1'b1;
        end else begin
          idx++;
        end
      end
      // The timer may only be turned off when the machine idles with nobody asleep.
      if (r.cpu_idle && !woke && shadow_fill == 0) begin
        dis = !r.future_pending;
        yld = 1'b0;
      end else begin
        dis = 1'b0;
        yld = shadow_preempt;
      end
      expect_result(make_result(KIND_SUMMARY, 8'h00, dis, yld, 1'b1));
    end
  endfunction

  // Mostly back-to-back transactions, some short pauses and a few long ones.
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Delays are mostly short so that the table keeps draining; wide ones are
  // only used near the end, since they would hold a slot for the whole run.
  function automatic logic [15:0] draw_delay(bit wide);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 16) return 16'($urandom_range(0, 8));
    if (pick < 19) return 16'($urandom_range(0, 200));
    return wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 1000));
  endfunction

  // The ignored fields carry random values so that every input bit toggles.
  function automatic void push_sleep(logic [7:0] id, logic [15:0] delay);
    req_t r;
    r.req_type       = REQ_SLEEP;
    r.thread_id      = id;
    r.sleep_ticks    = delay;
    r.cpu_idle       = 1'($urandom_range(0, 1));
    r.future_pending = 1'($urandom_range(0, 1));
    queue_request(r);
  endfunction

  function automatic void push_tick(logic idle, logic fut);
    req_t r;
    r.req_type       = REQ_TICK;
    r.thread_id      = 8'($urandom);
    r.sleep_ticks    = 16'($urandom);
    r.cpu_idle       = idle;
    r.future_pending = fut;
    queue_request(r);
  endfunction

  // A random phase is a string of sleep bursts, each followed by a few ticks.
  // Now and then a long burst overfills the table to provoke rejections.
  function automatic void add_random_phase(int count, bit wide);
    int added;
    int burst;
    int j;
    added = 0;
    while (added < count) begin
      burst = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(0, 5);
      for (j = 0; j < burst; j++) push_sleep(8'($urandom), draw_delay(wide));
      added += burst;
      burst = $urandom_range(1, 4);
      for (j = 0; j < burst; j++) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      added += burst;
    end
  endfunction

  // Driver: a transaction is accepted at an edge with start high and busy low.
  // The next request, or a pause, is chosen in the same step, and each driven
  // signal gets exactly one nonblocking assignment per edge.
  always @(posedge clk) begin : driver
    logic next_start;
    req_t next_req;
    int   next_gap;
    if (rst) begin
      start       <= 1'b0;
      req         <= '0;
      idle_cycles <= 0;
    end else begin
      next_start = start;
      next_req   = req;
      next_gap   = idle_cycles;
      if (start && !busy) begin
        predict_results(req);
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (next_gap > 0) begin
          next_gap--;
        end else if (queued_requests.size() > 0) begin
          next_req   = queued_requests.pop_front();
          next_start = 1'b1;
          next_gap   = draw_gap();
        end
      end
      start       <= next_start;
      req         <= next_req;
      idle_cycles <= next_gap;
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  function automatic void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t exp_res;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $error("result_kind: expected none, got %0h (unexpected result)", result.result_kind);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("result_kind", 8'(exp_res.result_kind), 8'(result.result_kind));
        compare_field("woken_id", exp_res.woken_id, result.woken_id);
        compare_field("disable_timer", 8'(exp_res.disable_timer), 8'(result.disable_timer));
        compare_field("yield_on_return", 8'(exp_res.yield_on_return),
                      8'(result.yield_on_return));
        compare_field("last", 8'(exp_res.last), 8'(result.last));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Waits at a falling edge, where everything has settled, until every request
  // has been accepted and every expected result has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (queued_requests.size() != 0 || start || busy || pending_results.size() != 0);
  endtask

  // Writes the scheduler register; only called while the block is quiet.
  task automatic write_preempt(logic value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    shadow_preempt = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'($urandom_range(0, 1));
    @(negedge clk);
  endtask

  initial begin : stimulus
    int i;
    shadow_ticks   = '0;
    shadow_fill    = 0;
    shadow_preempt = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ticks on an empty table: timer off, timer kept for future interrupts,
    // and a busy CPU that gets a yield.
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    // Zero delay wakes on the next tick; both extreme ids, woken oldest first.
    push_sleep(8'hFF, 16'h0000);
    push_sleep(8'h00, 16'h0000);
    push_tick(1'b1, 1'b0);
    // Fill the table, overflow it once, then wake the earliest sleepers.
    for (i = 0; i < TABLE_DEPTH; i++) push_sleep(8'(8'h10 + i), 16'(i));
    push_sleep(8'hEE, 16'h0001);
    push_tick(1'b1, 1'b0);
    wait_quiet();

    // Random phases under both scheduler settings. No transaction is free of
    // results, so the block is idle as soon as the last one has arrived.
    write_preempt(1'b0);
    add_random_phase(105, 1'b0);
    wait_quiet();
    write_preempt(1'b1);
    add_random_phase(105, 1'b0);
    wait_quiet();
    write_preempt(1'b0);
    add_random_phase(105, 1'b0);
    wait_quiet();
    write_preempt(1'b1);
    add_random_phase(100, 1'b1);
    // The widest delays go last, since such sleepers never wake in this run.
    push_sleep(8'hA5, 16'hFFFF);
    push_sleep(8'h5A, 16'h8000);
    push_tick(1'b1, 1'b1);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
